>>> src/swdm_pkg.sv
// Package: shared types and constants of the SWD master transfer engine.
package swdm_pkg;

  localparam int unsigned DataLen = 33;
  localparam int unsigned HdrLen  = 8;
  localparam int unsigned AckLen  = 3;

  localparam logic [2:0] AckOk    = 3'd1;
  localparam logic [2:0] AckWait  = 3'd2;
  localparam logic [2:0] AckFault = 3'd4;

  localparam logic [1:0] CfgTurnaround = 2'd0;
  localparam logic [1:0] CfgIdleCount  = 2'd1;
  localparam logic [1:0] CfgDummy      = 2'd2;

  typedef enum logic [3:0] {
    PhIdle      = 4'd0,
    PhHdr       = 4'd1,
    PhTrnA      = 4'd2,
    PhAck       = 4'd3,
    PhTrnB      = 4'd4,
    PhWdata     = 4'd5,
    PhRdata     = 4'd6,
    PhTrnC      = 4'd7,
    PhIdleDrive = 4'd8,
    PhWfDread   = 4'd9,
    PhWfTrn     = 4'd10,
    PhWfDwrite  = 4'd11,
    PhBackoff   = 4'd12
  } swdm_phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StWait     = 3'd1,
    StFault    = 3'd2,
    StProtocol = 3'd3,
    StParity   = 3'd4
  } swdm_status_e;

  typedef struct packed {
    logic        kind;
    logic        read_not_write;
    logic [7:0]  request_header;
    logic [31:0] write_word;
    logic        line_in;
  } swdm_in_t;

  typedef struct packed {
    logic        line_out;
    logic        line_drive_enable;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  result_status;
    logic [2:0]  raw_ack;
    logic [31:0] read_word;
  } swdm_out_t;

  typedef struct packed {
    logic [2:0] turnaround_cycles;
    logic [7:0] idle_cycle_count;
    logic       dummy_data_phase;
  } swdm_cfg_t;

  typedef struct packed {
    swdm_phase_e phase;
    logic [5:0]  bit_counter;
    logic [31:0] shift_word;
    logic [7:0]  header_latch;
    logic        direction_latch;
    logic        parity_accumulator;
    logic [2:0]  ack_latch;
    logic [7:0]  idle_counter;
  } swdm_state_t;

endpackage

>>> src/swdm_step.sv
// Combinational bit step: next engine state and line outputs for one SWCLK cycle.
module swdm_step (
  input  swdm_pkg::swdm_state_t state_i,
  input  swdm_pkg::swdm_in_t    item_i,
  input  swdm_pkg::swdm_cfg_t   cfg_i,
  output swdm_pkg::swdm_state_t state_o,
  output swdm_pkg::swdm_out_t   res_o
);

  function automatic logic [8:0] trn_len(input logic [2:0] t);
    logic [8:0] r;
    if (t == 3'd0) begin
      r = 9'd1;
    end else if (t > 3'd4) begin
      r = 9'd4;
    end else begin
      r = {6'd0, t};
    end
    return r;
  endfunction

  function automatic logic [8:0] phase_len(input swdm_pkg::swdm_phase_e p,
                                           input swdm_pkg::swdm_cfg_t c);
    logic [8:0] r;
    case (p)
      swdm_pkg::PhHdr:       r = 9'(swdm_pkg::HdrLen);
      swdm_pkg::PhTrnA,
      swdm_pkg::PhTrnB,
      swdm_pkg::PhTrnC,
      swdm_pkg::PhWfTrn:     r = trn_len(c.turnaround_cycles);
      swdm_pkg::PhAck:       r = 9'(swdm_pkg::AckLen);
      swdm_pkg::PhWdata,
      swdm_pkg::PhRdata:     r = 9'(swdm_pkg::DataLen);
      swdm_pkg::PhIdleDrive: r = {1'b0, c.idle_cycle_count};
      swdm_pkg::PhWfDread,
      swdm_pkg::PhWfDwrite:  r = c.dummy_data_phase ? 9'(swdm_pkg::DataLen) : 9'd0;
      swdm_pkg::PhBackoff:   r = trn_len(c.turnaround_cycles) + 9'(swdm_pkg::DataLen);
      default:               r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic swdm_pkg::swdm_phase_e follow(input swdm_pkg::swdm_phase_e p,
                                                   input logic [2:0] ack,
                                                   input logic dir);
    swdm_pkg::swdm_phase_e r;
    case (p)
      swdm_pkg::PhHdr:  r = swdm_pkg::PhTrnA;
      swdm_pkg::PhTrnA: r = swdm_pkg::PhAck;
      swdm_pkg::PhAck: begin
        if (ack == swdm_pkg::AckOk) begin
          r = dir ? swdm_pkg::PhRdata : swdm_pkg::PhTrnB;
        end else if (ack == swdm_pkg::AckWait || ack == swdm_pkg::AckFault) begin
          r = dir ? swdm_pkg::PhWfDread : swdm_pkg::PhWfTrn;
        end else begin
          r = swdm_pkg::PhBackoff;
        end
      end
      swdm_pkg::PhTrnB:    r = swdm_pkg::PhWdata;
      swdm_pkg::PhWdata:   r = swdm_pkg::PhIdleDrive;
      swdm_pkg::PhRdata:   r = swdm_pkg::PhTrnC;
      swdm_pkg::PhTrnC:    r = swdm_pkg::PhIdleDrive;
      swdm_pkg::PhWfDread: r = swdm_pkg::PhWfTrn;
      swdm_pkg::PhWfTrn:   r = dir ? swdm_pkg::PhIdle : swdm_pkg::PhWfDwrite;
      default:             r = swdm_pkg::PhIdle;
    endcase
    return r;
  endfunction

  function automatic swdm_pkg::swdm_phase_e skip_empty(input swdm_pkg::swdm_phase_e p,
                                                       input swdm_pkg::swdm_cfg_t c);
    swdm_pkg::swdm_phase_e r;
    r = p;
    if (p == swdm_pkg::PhIdleDrive && c.idle_cycle_count == 8'd0) begin
      r = swdm_pkg::PhIdle;
    end else if (p == swdm_pkg::PhWfDread && !c.dummy_data_phase) begin
      r = swdm_pkg::PhWfTrn;
    end else if (p == swdm_pkg::PhWfDwrite && !c.dummy_data_phase) begin
      r = swdm_pkg::PhIdle;
    end
    return r;
  endfunction

  swdm_pkg::swdm_state_t st;
  swdm_pkg::swdm_phase_e cur;
  logic [8:0]            cnt;
  logic [8:0]            cnt_inc;
  logic                  lo;
  logic                  oe;

  always_comb begin
    st    = state_i;
    res_o = '0;
    lo    = 1'b0;
    oe    = 1'b1;
    cnt   = 9'd0;
    cnt_inc = 9'd0;
    cur   = st.phase;

    if (st.phase == swdm_pkg::PhIdle && item_i.kind) begin
      st.direction_latch    = item_i.read_not_write;
      st.header_latch       = item_i.request_header;
      st.shift_word         = item_i.read_not_write ? 32'd0 : item_i.write_word;
      st.parity_accumulator = 1'b0;
      st.ack_latch          = 3'd0;
      st.bit_counter        = 6'd0;
      st.idle_counter       = 8'd0;
      st.phase              = swdm_pkg::PhHdr;
    end

    cur = st.phase;
    if (cur != swdm_pkg::PhIdle) begin
      res_o.busy_res = 1'b1;
      cnt = (cur == swdm_pkg::PhIdleDrive) ? {1'b0, st.idle_counter}
                                           : {3'd0, st.bit_counter};
      case (cur)
        swdm_pkg::PhHdr: lo = st.header_latch[cnt[2:0]];
        swdm_pkg::PhAck: begin
          oe = 1'b0;
          if (cnt < 9'(swdm_pkg::AckLen)) begin
            st.ack_latch[cnt[1:0]] = st.ack_latch[cnt[1:0]] | item_i.line_in;
          end
        end
        swdm_pkg::PhWdata: lo = (cnt < 9'd32) ? st.shift_word[cnt[4:0]] : ^st.shift_word;
        swdm_pkg::PhRdata: begin
          oe = 1'b0;
          if (cnt < 9'd32) begin
            st.shift_word[cnt[4:0]] = st.shift_word[cnt[4:0]] | item_i.line_in;
          end else begin
            st.parity_accumulator = item_i.line_in ^ (^st.shift_word);
          end
        end
        swdm_pkg::PhIdleDrive,
        swdm_pkg::PhWfDwrite: oe = 1'b1;
        default: oe = 1'b0;
      endcase

      cnt_inc = cnt + 9'd1;
      if (cnt_inc >= phase_len(cur, cfg_i)) begin
        st.phase = skip_empty(follow(cur, st.ack_latch, st.direction_latch), cfg_i);
        st.bit_counter  = 6'd0;
        st.idle_counter = 8'd0;
      end else if (cur == swdm_pkg::PhIdleDrive) begin
        st.idle_counter = cnt_inc[7:0];
      end else begin
        st.bit_counter = cnt_inc[5:0];
      end

      if (st.phase == swdm_pkg::PhIdle) begin
        res_o.done_res = 1'b1;
        res_o.raw_ack  = st.ack_latch;
        if (st.ack_latch == swdm_pkg::AckOk) begin
          res_o.result_status = (st.direction_latch && st.parity_accumulator)
                                ? swdm_pkg::StParity : swdm_pkg::StOk;
          if (st.direction_latch) begin
            res_o.read_word = st.shift_word;
          end
        end else if (st.ack_latch == swdm_pkg::AckWait) begin
          res_o.result_status = swdm_pkg::StWait;
        end else if (st.ack_latch == swdm_pkg::AckFault) begin
          res_o.result_status = swdm_pkg::StFault;
        end else begin
          res_o.result_status = swdm_pkg::StProtocol;
        end
      end
    end

    res_o.line_out          = oe & lo;
    res_o.line_drive_enable = oe;
    state_o                 = st;
  end

endmodule

>>> src/swd_master_transfer_engine_top.sv
// Top level: SWD master transfer engine with state, configuration and result registers.
// Each accepted input transfer is one SWCLK cycle and yields exactly one result transfer,
// which lands in the result register in the next cycle. The bit state machine advances once per
// accepted transfer, so the block takes one item per clock unless a held result stalls the input;
// the result register holds a finished result while the next item is accepted as long as the
// result side takes it the same cycle. Configuration writes are registered; write only between transfers.
module swd_master_transfer_engine_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swdm_pkg::swdm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swdm_pkg::swdm_out_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  swdm_pkg::swdm_state_t state_q;
  swdm_pkg::swdm_state_t state_d;
  swdm_pkg::swdm_cfg_t   cfg_q;
  swdm_pkg::swdm_out_t   res_d;
  swdm_pkg::swdm_out_t   res_q;
  logic                  out_valid_q;
  logic                  accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  swdm_step u_step (
    .state_i (state_q),
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turnaround_cycles <= 3'd1;
      cfg_q.idle_cycle_count  <= 8'd0;
      cfg_q.dummy_data_phase  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        swdm_pkg::CfgTurnaround: cfg_q.turnaround_cycles <= cfg_data_i[2:0];
        swdm_pkg::CfgIdleCount:  cfg_q.idle_cycle_count  <= cfg_data_i;
        swdm_pkg::CfgDummy:      cfg_q.dummy_data_phase  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

endmodule

>>> tb/tb_top.sv
// Testbench for the SWD master transfer engine: predicts every SWCLK cycle and checks each result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  swdm_pkg::swdm_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  swdm_pkg::swdm_out_t out_data_o;
  logic                cfg_we_i;
  logic [1:0]          cfg_index_i;
  logic [7:0]          cfg_data_i;

  swd_master_transfer_engine_top DUT (.*);

  // engine state and register copies
  swdm_pkg::swdm_phase_e st_phase = swdm_pkg::PhIdle;
  logic [5:0]  st_bits  = '0;
  logic [31:0] st_word  = '0;
  logic [7:0]  st_hdr   = '0;
  logic        st_read  = 1'b0;
  logic        st_par   = 1'b0;
  logic [2:0]  st_ack   = '0;
  logic [7:0]  st_idle  = '0;
  logic [2:0]  reg_trn   = 3'd1;
  logic [7:0]  reg_idle  = 8'd0;
  logic        reg_dummy = 1'b0;

  swdm_pkg::swdm_in_t  swclk_items_q[$];
  swdm_pkg::swdm_in_t  xfer_plan_q[$];
  swdm_pkg::swdm_out_t cycle_results_q[$];

  int n_fail    = 0;
  int n_results = 0;
  int n_pushed  = 0;
  int tx_gap    = 0;
  int tx_run    = 100;
  bit tx_quiet  = 1'b0;
  int rx_wait   = 0;
  int rx_run    = 100;
  bit rx_quiet  = 1'b0;
  swdm_pkg::swdm_out_t got_res;
  swdm_pkg::swdm_out_t want_res;

  function automatic int unsigned trn_eff();
    if (reg_trn < 3'd1) return 1;
    if (reg_trn > 3'd4) return 4;
    return {29'd0, reg_trn};
  endfunction

  function automatic int unsigned span_of(swdm_pkg::swdm_phase_e p);
    case (p)
      swdm_pkg::PhHdr: return swdm_pkg::HdrLen;
      swdm_pkg::PhTrnA, swdm_pkg::PhTrnB, swdm_pkg::PhTrnC,
      swdm_pkg::PhWfTrn: return trn_eff();
      swdm_pkg::PhAck: return swdm_pkg::AckLen;
      swdm_pkg::PhWdata, swdm_pkg::PhRdata: return swdm_pkg::DataLen;
      swdm_pkg::PhIdleDrive: return {24'd0, reg_idle};
      swdm_pkg::PhWfDread, swdm_pkg::PhWfDwrite: return reg_dummy ? swdm_pkg::DataLen : 0;
      swdm_pkg::PhBackoff: return trn_eff() + swdm_pkg::DataLen;
      default: return 0;
    endcase
  endfunction

  function automatic swdm_pkg::swdm_phase_e after_phase(swdm_pkg::swdm_phase_e p);
    case (p)
      swdm_pkg::PhHdr: return swdm_pkg::PhTrnA;
      swdm_pkg::PhTrnA: return swdm_pkg::PhAck;
      swdm_pkg::PhAck: begin
        if (st_ack == swdm_pkg::AckOk) return st_read ? swdm_pkg::PhRdata : swdm_pkg::PhTrnB;
        if (st_ack == swdm_pkg::AckWait || st_ack == swdm_pkg::AckFault)
          return st_read ? swdm_pkg::PhWfDread : swdm_pkg::PhWfTrn;
        return swdm_pkg::PhBackoff;
      end
      swdm_pkg::PhTrnB: return swdm_pkg::PhWdata;
      swdm_pkg::PhWdata: return swdm_pkg::PhIdleDrive;
      swdm_pkg::PhRdata: return swdm_pkg::PhTrnC;
      swdm_pkg::PhTrnC: return swdm_pkg::PhIdleDrive;
      swdm_pkg::PhWfDread: return swdm_pkg::PhWfTrn;
      swdm_pkg::PhWfTrn: return st_read ? swdm_pkg::PhIdle : swdm_pkg::PhWfDwrite;
      default: return swdm_pkg::PhIdle;
    endcase
  endfunction

  function automatic swdm_pkg::swdm_phase_e next_live_phase(swdm_pkg::swdm_phase_e p);
    swdm_pkg::swdm_phase_e n;
    n = after_phase(p);
    while (n != swdm_pkg::PhIdle && span_of(n) == 0) n = after_phase(n);
    return n;
  endfunction

  // advance the engine by one SWCLK cycle and return the line and status it shows
  function automatic swdm_pkg::swdm_out_t run_swclk_cycle(swdm_pkg::swdm_in_t it);
    swdm_pkg::swdm_out_t r;
    int unsigned         cnt;
    logic                drv;
    r = '0;
    drv = 1'b1;
    if (st_phase == swdm_pkg::PhIdle && it.kind) begin
      st_read = it.read_not_write;
      st_hdr = it.request_header;
      st_word = st_read ? 32'd0 : it.write_word;
      st_par = 1'b0;
      st_ack = '0;
      st_bits = '0;
      st_idle = '0;
      st_phase = swdm_pkg::PhHdr;
    end
    if (st_phase != swdm_pkg::PhIdle) begin
      r.busy_res = 1'b1;
      cnt = (st_phase == swdm_pkg::PhIdleDrive) ? {24'd0, st_idle} : {26'd0, st_bits};
      case (st_phase)
        swdm_pkg::PhHdr: r.line_out = st_hdr[cnt[2:0]];
        swdm_pkg::PhAck: begin
          drv = 1'b0;
          if (cnt < 3) st_ack[cnt[1:0]] = st_ack[cnt[1:0]] | it.line_in;
        end
        swdm_pkg::PhWdata: r.line_out = (cnt < 32) ? st_word[cnt[4:0]] : ^st_word;
        swdm_pkg::PhRdata: begin
          drv = 1'b0;
          if (cnt < 32) st_word[cnt[4:0]] = st_word[cnt[4:0]] | it.line_in;
          else st_par = it.line_in ^ (^st_word);
        end
        swdm_pkg::PhIdleDrive, swdm_pkg::PhWfDwrite: ;
        default: drv = 1'b0;
      endcase
      cnt++;
      if (cnt >= span_of(st_phase)) begin
        st_phase = next_live_phase(st_phase);
        st_bits = '0;
        st_idle = '0;
      end else if (st_phase == swdm_pkg::PhIdleDrive) begin
        st_idle = cnt[7:0];
      end else begin
        st_bits = cnt[5:0];
      end
      if (st_phase == swdm_pkg::PhIdle) begin
        r.done_res = 1'b1;
        r.raw_ack = st_ack;
        if (st_ack == swdm_pkg::AckOk) begin
          r.result_status = (st_read && st_par) ? swdm_pkg::StParity : swdm_pkg::StOk;
          if (st_read) r.read_word = st_word;
        end else if (st_ack == swdm_pkg::AckWait) begin
          r.result_status = swdm_pkg::StWait;
        end else if (st_ack == swdm_pkg::AckFault) begin
          r.result_status = swdm_pkg::StFault;
        end else begin
          r.result_status = swdm_pkg::StProtocol;
        end
      end
    end
    if (!drv) r.line_out = 1'b0;
    r.line_drive_enable = drv;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_fail++;
    if (n_fail <= 40)
      $display("mismatch %s at result %0d: got %h want %h", what, n_results, got, want);
  endtask

  function automatic int pick_gap(bit quiet, int pct);
    int r;
    if (quiet || int'($urandom_range(99)) >= pct) return 0;
    r = int'($urandom_range(99));
    if (r < 75) return int'($urandom_range(3, 1));
    if (r < 95) return int'($urandom_range(12, 4));
    return int'($urandom_range(60, 20));
  endfunction

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        cycle_results_q.push_back(run_swclk_cycle(in_data_i));
        tx_gap = pick_gap(tx_quiet, 40);
        if (--tx_run == 0) begin
          tx_quiet = !tx_quiet;
          tx_run = int'($urandom_range(200, 40));
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap == 0 && swclk_items_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= swclk_items_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_res = out_data_o;
        if (cycle_results_q.size() == 0) begin
          flag_mismatch("transfer with nothing due", 32'd0, 32'd0);
        end else begin
          want_res = cycle_results_q.pop_front();
          if (got_res.line_out !== want_res.line_out)
            flag_mismatch("line_out", 32'(got_res.line_out), 32'(want_res.line_out));
          if (got_res.line_drive_enable !== want_res.line_drive_enable)
            flag_mismatch("line_drive_enable", 32'(got_res.line_drive_enable),
                          32'(want_res.line_drive_enable));
          if (got_res.busy_res !== want_res.busy_res)
            flag_mismatch("busy_res", 32'(got_res.busy_res), 32'(want_res.busy_res));
          if (got_res.done_res !== want_res.done_res)
            flag_mismatch("done_res", 32'(got_res.done_res), 32'(want_res.done_res));
          if (got_res.result_status !== want_res.result_status)
            flag_mismatch("result_status", 32'(got_res.result_status),
                          32'(want_res.result_status));
          if (got_res.raw_ack !== want_res.raw_ack)
            flag_mismatch("raw_ack", 32'(got_res.raw_ack), 32'(want_res.raw_ack));
          if (got_res.read_word !== want_res.read_word)
            flag_mismatch("read_word", got_res.read_word, want_res.read_word);
        end
        n_results++;
        if (n_results == 450) rx_wait = 250;
        if (--rx_run == 0) begin
          rx_quiet = !rx_quiet;
          rx_run = int'($urandom_range(200, 40));
        end
      end
      if (rx_wait == 0) rx_wait = pick_gap(rx_quiet, 15);
      if (rx_wait > 0) begin
        out_ready_i <= 1'b0;
        rx_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic swdm_pkg::swdm_in_t tick_item(bit k, bit lin);
    swdm_pkg::swdm_in_t t;
    t.kind = k;
    t.read_not_write = 1'($urandom_range(1));
    t.request_header = 8'($urandom);
    t.write_word = $urandom;
    t.line_in = lin;
    return t;
  endfunction

  // during a transfer a start request now and then must be ignored
  task automatic plan_busy(int n, bit lin_fixed = 1'b0, bit lin = 1'b0);
    repeat (n)
      xfer_plan_q.push_back(tick_item($urandom_range(7) == 0,
                                      lin_fixed ? lin : 1'($urandom_range(1))));
  endtask

  task automatic plan_transfer(bit rnw, logic [7:0] h, logic [31:0] w, logic [2:0] a,
                               logic [31:0] rd, bit flip, int idle_len);
    swdm_pkg::swdm_in_t t;
    int                 tl;
    tl = int'(trn_eff());
    xfer_plan_q.delete();
    t = tick_item(1'b1, 1'($urandom_range(1)));
    t.read_not_write = rnw;
    t.request_header = h;
    t.write_word = w;
    xfer_plan_q.push_back(t);
    plan_busy(int'(swdm_pkg::HdrLen) - 1 + tl);
    for (int i = 0; i < 3; i++) plan_busy(1, 1'b1, a[i]);
    if (a == swdm_pkg::AckOk && rnw) begin
      for (int i = 0; i < 32; i++) plan_busy(1, 1'b1, rd[i]);
      plan_busy(1, 1'b1, (^rd) ^ flip);
      plan_busy(tl + idle_len);
    end else if (a == swdm_pkg::AckOk) begin
      plan_busy(tl + int'(swdm_pkg::DataLen) + idle_len);
    end else if (a == swdm_pkg::AckWait || a == swdm_pkg::AckFault) begin
      plan_busy(tl + (reg_dummy ? int'(swdm_pkg::DataLen) : 0));
    end else begin
      plan_busy(tl + int'(swdm_pkg::DataLen));
    end
  endtask

  task automatic push_plan(int lo, int hi);
    for (int i = lo; i < hi && i < xfer_plan_q.size(); i++) begin
      swclk_items_q.push_back(xfer_plan_q[i]);
      n_pushed++;
    end
  endtask

  task automatic push_item(swdm_pkg::swdm_in_t t);
    swclk_items_q.push_back(t);
    n_pushed++;
  endtask

  task automatic wait_drained();
    while (swclk_items_q.size() || in_valid_i || cycle_results_q.size()) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      swdm_pkg::CfgTurnaround: reg_trn = val[2:0];
      swdm_pkg::CfgIdleCount: reg_idle = val;
      swdm_pkg::CfgDummy: reg_dummy = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(logic [2:0] trn, logic [7:0] idle, logic dummy);
    wait_drained();
    set_reg(swdm_pkg::CfgTurnaround, {5'd0, trn});
    set_reg(swdm_pkg::CfgIdleCount, idle);
    set_reg(swdm_pkg::CfgDummy, {7'd0, dummy});
  endtask

  task automatic random_transfer();
    logic [2:0] a;
    int         r;
    r = int'($urandom_range(99));
    if (r < 50) a = swdm_pkg::AckOk;
    else if (r < 65) a = swdm_pkg::AckWait;
    else if (r < 80) a = swdm_pkg::AckFault;
    else a = 3'($urandom_range(7));
    plan_transfer(1'($urandom_range(1)), 8'($urandom), $urandom, a, $urandom,
                  $urandom_range(99) < 15, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
  endtask

  // noise, then idle ticks until the engine is back at rest
  task automatic noise_burst();
    logic [63:0] r;
    repeat ($urandom_range(40, 5)) begin
      r = {$urandom, $urandom};
      if ($urandom_range(3) != 0) r[42] = 1'b0;
      push_item(swdm_pkg::swdm_in_t'(r[42:0]));
    end
    wait_drained();
    while (st_phase != swdm_pkg::PhIdle) begin
      repeat (8) push_item(tick_item(1'b0, 1'($urandom_range(1))));
      wait_drained();
    end
  endtask

  task automatic run_phase(logic [2:0] trn, logic [7:0] idle, logic dummy, int budget);
    int stop_at;
    int r;
    set_all(trn, idle, dummy);
    stop_at = n_pushed + budget;
    while (n_pushed < stop_at) begin
      r = int'($urandom_range(99));
      if (r < 80) random_transfer();
      else if (r < 88) noise_burst();
      else if (r < 95)
        repeat ($urandom_range(5, 1)) push_item(tick_item(1'b0, 1'($urandom_range(1))));
      else wait_drained();
      repeat ($urandom_range(2)) push_item(tick_item(1'b0, 1'($urandom_range(1))));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    clk_i = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    repeat (3) push_item(tick_item(1'b0, 1'b1));
    plan_transfer(1'b0, 8'hFF, 32'hFFFF_FFFF, swdm_pkg::AckOk, 32'd0, 1'b0, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
    plan_transfer(1'b1, 8'h00, 32'd0, swdm_pkg::AckOk, 32'hFFFF_FFFF, 1'b0, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
    plan_transfer(1'b1, 8'hA5, 32'h0, swdm_pkg::AckOk, 32'h0, 1'b1, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
    plan_transfer(1'b0, 8'h81, 32'h1234_5678, swdm_pkg::AckWait, 32'd0, 1'b0, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
    plan_transfer(1'b1, 8'h99, 32'd0, swdm_pkg::AckFault, 32'd0, 1'b0, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
    plan_transfer(1'b1, 8'h3C, 32'd0, 3'd7, 32'd0, 1'b0, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());
    plan_transfer(1'b0, 8'hC3, 32'h8000_0001, 3'd0, 32'd0, 1'b0, int'(reg_idle));
    push_plan(0, xfer_plan_q.size());

    // change the idle count while a read sits in its header
    plan_transfer(1'b1, 8'h5A, 32'd0, swdm_pkg::AckOk, 32'hDEAD_BEEF, 1'b0, 3);
    push_plan(0, 4);
    wait_drained();
    set_reg(swdm_pkg::CfgIdleCount, 8'd3);
    push_plan(4, xfer_plan_q.size());

    run_phase(3'd4, 8'd255, 1'b1, 40);
    run_phase(3'd0, 8'd1, 1'b1, 40);
    run_phase(3'd7, 8'd0, 1'b0, 40);
    run_phase(3'd2, 8'd17, 1'b1, 40);
    run_phase(3'($urandom_range(7)), 8'($urandom_range(7)), 1'($urandom_range(1)), 40);
    run_phase(3'($urandom_range(7)), 8'($urandom_range(7)), 1'($urandom_range(1)), 40);
    run_phase(3'd3, 8'd0, 1'b0, 40);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (cycle_results_q.size() != 0)
      flag_mismatch("results never seen", 32'(cycle_results_q.size()), 32'd0);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> swd_master_transfer_engine_top.f
src/swdm_pkg.sv
src/swdm_step.sv
src/swd_master_transfer_engine_top.sv
tb/tb_top.sv
